// ----- rtl/core/maf_pkg.sv -----
package maf_pkg;

  // Fixed field widths of the channels
  localparam int unsigned CFG_W = 9;
  localparam int unsigned AVG_W = 16;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_UPD  = 2'b10
  } maf_state_e;

endpackage

// ----- rtl/core/maf_if.sv -----
// Sample channel
interface maf_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// Result channel
interface maf_out_if;
  logic                        valid;
  logic                        ready;
  logic [maf_pkg::AVG_W-1:0]   average;
  logic                        window_full;

  modport source (output valid, output average, output window_full, input ready);
  modport sink   (input valid, input average, input window_full, output ready);
endinterface

// Window length write channel
interface maf_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [maf_pkg::CFG_W-1:0] window_len;

  modport source (output valid, output window_len, input ready);
  modport sink   (input valid, input window_len, output ready);
endinterface

// ----- rtl/core/moving_average_filter.sv -----
// Channel   Dir   Beat payload             Accepted when
// -------   ---   ----------------------   -------------------------
// in_i      in    sample                   in_i.valid && in_i.ready
// out_o     out   average, window_full     out_o.valid && out_o.ready
// cfg_i     in    window_len               cfg_i.valid (ready tied 1)
//
// A sample is taken only in the idle state, which reads the ring entry
// at the write pointer; the update state then updates sum/pointer/count,
// writes the ring back and pushes into a SAMPLE_BITS-stage divider pipe
// that yields the mean. No new sample is taken until the update is done.
// Reset clears sum, pointer and count; ring contents stay unknown.
// A stall on out_o freezes the divider pipe; a finished update waits in
// the update state until the pipe can take it.
module moving_average_filter #(
  parameter int unsigned MAX_WINDOW  = 256,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  maf_in_if.sink    in_i,
  maf_out_if.source out_o,
  maf_cfg_if.sink   cfg_i
);
  import maf_pkg::*;

  localparam int unsigned PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
  // sum <= MAX_WINDOW * (2^SAMPLE_BITS - 1)
  localparam int unsigned SUM_W = SAMPLE_BITS + PTR_W;
  localparam int unsigned LW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // registers
  maf_state_e             state_q, state_d;
  logic [CFG_W-1:0]       win_len_q;
  logic [SUM_W-1:0]       sum_q;
  logic [PTR_W-1:0]       wpos_q;
  logic [CNT_W-1:0]       fill_q;
  logic [SAMPLE_BITS-1:0] smp_q;
  logic [PTR_W-1:0]       pos_q;

  // ring
  logic [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] ring_rd_q;
  logic                   ring_re;
  logic                   ring_we;

  // working signals
  logic [LW-1:0]    wl_ext;
  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] pos_cur;
  logic [CNT_W-1:0] pos_inc;
  logic [PTR_W-1:0] pos_nxt;
  logic             was_full;
  logic [CNT_W-1:0] fill_d;
  logic [SUM_W-1:0] sum_d;
  logic             in_acc;
  logic             cfg_acc;
  logic             adv;
  logic             push;

  logic [SAMPLE_BITS-1:0] div_quo;
  logic                   div_full;
  logic                   div_vld;

  // effective window: zero acts as one, clamp at MAX_WINDOW
  assign wl_ext = LW'(win_len_q);
  always_comb begin
    if (wl_ext == '0) begin
      len = CNT_W'(1);
    end else if (wl_ext > LW'(MAX_WINDOW)) begin
      len = CNT_W'(MAX_WINDOW);
    end else begin
      len = CNT_W'(wl_ext);
    end
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_acc     = cfg_i.valid;

  // write pointer past the window folds back to entry 0
  assign pos_cur = (CNT_W'(wpos_q) >= len) ? '0 : CNT_W'(wpos_q);

  // update step, uses the ring entry read when the sample was taken
  assign was_full = (fill_q >= len);
  assign fill_d   = was_full ? len : (fill_q + CNT_W'(1));
  assign sum_d    = sum_q - (was_full ? SUM_W'(ring_rd_q) : '0) + SUM_W'(smp_q);
  assign pos_inc  = CNT_W'(pos_q) + CNT_W'(1);
  assign pos_nxt  = (pos_inc >= len) ? '0 : PTR_W'(pos_inc);

  // divider pipe advances unless its last stage holds an untaken result
  assign adv     = !div_vld || out_o.ready;
  assign push    = (state_q == ST_UPD) && adv;
  assign ring_re = in_acc;
  assign ring_we = push;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (adv) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      win_len_q <= CFG_W'(16);
      sum_q     <= '0;
      wpos_q    <= '0;
      fill_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_acc) begin
        // new length restarts the window
        win_len_q <= cfg_i.window_len;
        sum_q     <= '0;
        wpos_q    <= '0;
        fill_q    <= '0;
      end else if (push) begin
        sum_q  <= sum_d;
        wpos_q <= pos_nxt;
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp_q <= in_i.sample;
      pos_q <= PTR_W'(pos_cur);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[pos_q] <= smp_q;
    end
    if (ring_re) begin
      ring_rd_q <= ring_mem[PTR_W'(pos_cur)];
    end
  end

  maf_div #(
    .QB (SAMPLE_BITS),
    .DW (CNT_W),
    .RW (SUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .adv_i   (adv),
    .rem_i   (sum_d),
    .den_i   (fill_d),
    .full_i  (fill_d == len),
    .valid_o (div_vld),
    .quo_o   (div_quo),
    .full_o  (div_full)
  );

  assign out_o.valid       = div_vld;
  assign out_o.average     = AVG_W'(div_quo);
  assign out_o.window_full = div_full;

`ifndef SYNTHESIS
  a_fill_in_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= len)
    else $error("fill count above window length");

  a_pos_in_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(wpos_q) < len)
    else $error("write pointer outside window");

  a_accept_then_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_UPD) && !in_i.ready)
    else $error("sample accepted without an update cycle");

  a_stall_holds_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) && !adv |=> (state_q == ST_UPD) && $stable(sum_q))
    else $error("update committed while divider pipe stalled");
`endif

endmodule

// ----- rtl/core/maf_div.sv -----
// Restoring divider, one quotient bit per stage, whole pipe stalls together.
module maf_div #(
  parameter int unsigned QB = 16,
  parameter int unsigned DW = 9,
  parameter int unsigned RW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic          adv_i,
  input  logic [RW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  input  logic          full_i,
  output logic          valid_o,
  output logic [QB-1:0] quo_o,
  output logic          full_o
);
  import maf_pkg::*;

  localparam int unsigned W = DW + QB;

  logic [W-1:0]  rem_q  [QB];
  logic [DW-1:0] den_q  [QB];
  logic [QB-1:0] quo_q  [QB];
  logic          full_q [QB];
  logic          vld_q  [QB];

  for (genvar g = 0; g < QB; g++) begin : g_stage
    logic [W-1:0]  rem_in;
    logic [DW-1:0] den_in;
    logic [QB-1:0] quo_in;
    logic          full_in;
    logic          vld_in;
    logic [W-1:0]  d_sh;
    logic          ge;
    logic [QB-1:0] quo_nxt;

    if (g == 0) begin : g_first
      assign rem_in  = W'(rem_i);
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign full_in = full_i;
      assign vld_in  = push_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign den_in  = den_q[g-1];
      assign quo_in  = quo_q[g-1];
      assign full_in = full_q[g-1];
      assign vld_in  = vld_q[g-1];
    end

    assign d_sh = W'(den_in) << (QB - 1 - g);
    assign ge   = (rem_in >= d_sh);

    always_comb begin
      quo_nxt             = quo_in;
      quo_nxt[QB - 1 - g] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (adv_i) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[g]  <= ge ? (rem_in - d_sh) : rem_in;
        den_q[g]  <= den_in;
        quo_q[g]  <= quo_nxt;
        full_q[g] <= full_in;
      end
    end
  end

  assign valid_o = vld_q[QB-1];
  assign quo_o   = quo_q[QB-1];
  assign full_o  = full_q[QB-1];

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

// Sample channel: smp_if (driven here). Result channel: mean_if (ready driven here).
// Window length register: cfg_if, written only while nothing is in flight.
module tb_top;
  import maf_pkg::*;

  localparam int unsigned SMP_W        = 16;
  localparam int unsigned WIN_MAX      = 256;
  localparam int unsigned SUM_W        = 24;
  // leave plenty of room for stray beats after the last result
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  // phase table marker: pick any 9-bit length at run time
  localparam int unsigned RND_WIN      = 1000;
  localparam int unsigned N_PHASES     = 15;

  typedef struct packed {
    logic [AVG_W-1:0] average;
    logic             window_full;
  } mean_beat_t;

  // stall profile of the two channels
  typedef enum logic [1:0] {
    PACE_SRC_LIGHT,   // sender idles 29%, receiver 57%
    PACE_SRC_HEAVY,   // sender idles 57%, receiver 29%
    PACE_FREE         // nobody idles
  } pace_e;

  // window length and sample count of each random phase
  int unsigned plan_len [N_PHASES] = '{1, 0, 256, 2, 300,
                                       7, 511, 3, 255, 16,
                                       33, RND_WIN, 5, 128, 16};
  int unsigned plan_cnt [N_PHASES] = '{40, 30, 300, 40, 100,
                                       60, 280, 50, 270, 80,
                                       120, 150, 60, 200, 150};

  logic clk;
  logic rst_n;

  maf_in_if #(.SAMPLE_BITS(SMP_W)) smp_if ();
  maf_out_if                       mean_if ();
  maf_cfg_if                       cfg_if ();

  moving_average_filter #(
    .MAX_WINDOW (WIN_MAX),
    .SAMPLE_BITS(SMP_W)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (smp_if),
    .out_o (mean_if),
    .cfg_i (cfg_if)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the window state
  // ---------------------------------------------------------------------------
  logic [SMP_W-1:0] ring_shadow [WIN_MAX];
  logic [SUM_W-1:0] sum_shadow;
  int unsigned      pos_shadow;
  int unsigned      fill_shadow;
  logic [CFG_W-1:0] len_reg;

  logic [SMP_W-1:0] sample_q [$];   // samples waiting for the driver
  mean_beat_t       mean_q [$];     // expected result beats, oldest first

  int unsigned beats_queued;
  int unsigned beats_out;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  bit          smp_took;            // sample beat taken at the last rising edge

  // Push one sample into the shadow window, return the mean beat it yields.
  function automatic mean_beat_t avg_push(logic [SMP_W-1:0] smp);
    int unsigned len;
    int unsigned pos;
    mean_beat_t  r;
    // zero acts as 1, anything past the ring depth saturates
    if (len_reg == 0) len = 1;
    else if (len_reg > WIN_MAX) len = WIN_MAX;
    else len = len_reg;
    pos = pos_shadow;
    if (pos >= len) pos = 0;
    if (fill_shadow >= len) begin
      // full window: oldest sample drops out, count stays saturated
      fill_shadow = len;
      sum_shadow  = sum_shadow - ring_shadow[pos];
    end else begin
      fill_shadow++;
    end
    sum_shadow       = sum_shadow + smp;
    ring_shadow[pos] = smp;
    pos++;
    if (pos >= len) pos = 0;
    pos_shadow    = pos;
    r.average     = AVG_W'(sum_shadow / fill_shadow);
    r.window_full = (fill_shadow == len);
    return r;
  endfunction

  // Mostly random, with a good share of the extremes and near-extremes.
  function automatic logic [SMP_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return SMP_W'($urandom_range(15));
      3: return {{(SMP_W-4){1'b1}}, 4'($urandom_range(15))};
      default: return SMP_W'($urandom);
    endcase
  endfunction

  task automatic set_pace(input pace_e p);
    case (p)
      PACE_SRC_LIGHT: begin src_idle_pct = 29; snk_idle_pct = 57; end
      PACE_SRC_HEAVY: begin src_idle_pct = 57; snk_idle_pct = 29; end
      default:        begin src_idle_pct = 0;  snk_idle_pct = 0;  end
    endcase
  endtask

  // Register write; any write restarts the window.
  task automatic write_window(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_if.valid      <= 1'b1;
    cfg_if.window_len <= v;
    do @(posedge clk); while (!cfg_if.ready);
    len_reg     = v;
    sum_shadow  = '0;
    pos_shadow  = 0;
    fill_shadow = 0;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic queue_sample(input logic [SMP_W-1:0] smp);
    sample_q.push_back(smp);
    beats_queued++;
  endtask

  // ---------------------------------------------------------------------------
  // Clock, cycle counter, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    cycle_cnt = 0;
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: inputs move on the falling edge only
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      // hold the sample beat until it is taken
      if (!smp_if.valid || smp_took) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          smp_if.valid  <= 1'b1;
          smp_if.sample <= sample_q.pop_front();
        end else begin
          smp_if.valid  <= 1'b0;
          smp_if.sample <= SMP_W'($urandom);   // junk while idle
        end
      end
      mean_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: both channels sampled on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    mean_beat_t want;
    smp_took = 1'b0;
    if (rst_n) begin
      smp_took = smp_if.valid && smp_if.ready;
      if (smp_took) mean_q.push_back(avg_push(smp_if.sample));
      if (mean_if.valid && mean_if.ready) begin
        beats_out++;
        if (mean_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result beat average %0d window_full %0b",
                   $time, mean_if.average, mean_if.window_full);
        end else begin
          want = mean_q.pop_front();
          if (mean_if.average !== want.average) begin
            err_cnt++;
            $display("%0t: average expected %0d actual %0d",
                     $time, want.average, mean_if.average);
          end
          if (mean_if.window_full !== want.window_full) begin
            err_cnt++;
            $display("%0t: window_full expected %0b actual %0b",
                     $time, want.window_full, mean_if.window_full);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed samples, then random phases per window length
  // ---------------------------------------------------------------------------
  initial begin
    logic [CFG_W-1:0] win;
    rst_n             = 1'b0;
    smp_if.valid      = 1'b0;
    smp_if.sample     = '0;
    mean_if.ready     = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.window_len = '0;
    beats_queued      = 0;
    beats_out         = 0;
    err_cnt           = 0;
    len_reg           = CFG_W'(16);   // power-up window length
    sum_shadow        = '0;
    pos_shadow        = 0;
    fill_shadow       = 0;
    set_pace(PACE_SRC_LIGHT);

    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed, default length of 16: extremes and bit patterns, then enough
    // all-ones samples to fill the window and overwrite the oldest entries.
    queue_sample('0);
    queue_sample('1);
    queue_sample(SMP_W'(1));
    queue_sample(16'h8000);
    queue_sample(16'h7fff);
    queue_sample(16'haaaa);
    queue_sample(16'h5555);
    repeat (13) queue_sample('1);
    wait (beats_out >= beats_queued);

    // Random phases; every write lands with the pipe empty.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph < 5) set_pace(PACE_SRC_LIGHT);
      else if (ph < 10) set_pace(PACE_SRC_HEAVY);
      else set_pace(PACE_FREE);
      if (plan_len[ph] == RND_WIN) win = CFG_W'($urandom);
      else win = CFG_W'(plan_len[ph]);
      write_window(win);
      repeat (plan_cnt[ph]) queue_sample(pick_sample());
      wait (beats_out >= beats_queued);
    end

    // catch late or extra beats
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && mean_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/maf_pkg.sv
rtl/core/maf_if.sv
rtl/core/maf_div.sv
rtl/core/moving_average_filter.sv
tb/tb_top.sv
